### hw/rtl/dnt_pkg.sv
// shared types and constants of the directory name table
package dnt_pkg;

	// fixed field widths of the request and response items
	localparam int REQ_W        = 3;
	localparam int NAME_IN_W    = 64;
	localparam int SECTOR_IO_W  = 10;
	localparam int INDEX_OUT_W  = 4;
	localparam int STATUS_W     = 2;

	// widest storage the parameters allow
	localparam int SECTOR_MAX_W = 32;
	localparam int INDEX_MAX_W  = 8;

	// parameter defaults
	localparam int ENTRIES_DEF     = 16;
	localparam int NAME_BYTES_DEF  = 8;
	localparam int SECTOR_BITS_DEF = 10;

	// name keys of the "." and ".." entries
	localparam logic [NAME_IN_W-1:0] KEY_DOT    = 64'h2E;
	localparam logic [NAME_IN_W-1:0] KEY_DOTDOT = 64'h2E2E;

	typedef enum logic [REQ_W-1:0] {
		REQ_LOOKUP     = 3'd0,
		REQ_ADD        = 3'd1,
		REQ_REMOVE     = 3'd2,
		REQ_SET_SECTOR = 3'd3,
		REQ_EMPTY      = 3'd4
	} dnt_req_t;

	typedef enum logic [STATUS_W-1:0] {
		STS_OK        = 2'd0,
		STS_NOT_FOUND = 2'd1,
		STS_DUPLICATE = 2'd2,
		STS_FULL      = 2'd3
	} dnt_status_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN,
		ST_FINISH
	} dnt_state_t;

endpackage

### hw/rtl/dnt_ram.sv
// single-port-write, single-port-read slot memory with registered read data
module dnt_ram #(
	parameter int DEPTH = 16,
	parameter int WIDTH = 75
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// read port, registered read data
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

### hw/rtl/directory_name_table.sv
// directory name table: slot memory scanned one slot per cycle per request
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+-----------------------------------------
//  req     | in        | req_valid/req_stall  | req_type, entry_name, is_file, sector_in
//  rsp     | out       | rsp_valid/rsp_stall  | status, sector_out, index_out, dir_empty
//
// one item at a time: a new item is taken only in the idle state, after the
// scan of the slot memory through its single read port and the finish step.
// the response is registered in the finish step, after the scan and drain steps.
// a held response blocks only the finish step; the next item may be taken
// while the response waits until the scan reaches the finish step.
// reset clears the valid bits at once; the memory itself needs no clearing.
module directory_name_table #(
	parameter int ENTRIES     = dnt_pkg::ENTRIES_DEF,
	parameter int NAME_BYTES  = dnt_pkg::NAME_BYTES_DEF,
	parameter int SECTOR_BITS = dnt_pkg::SECTOR_BITS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             req_valid,
	output logic                             req_stall,
	input  logic [dnt_pkg::REQ_W-1:0]        req_type,
	input  logic [dnt_pkg::NAME_IN_W-1:0]    entry_name,
	input  logic                             is_file,
	input  logic [dnt_pkg::SECTOR_IO_W-1:0]  sector_in,
	output logic                             rsp_valid,
	input  logic                             rsp_stall,
	output logic [dnt_pkg::STATUS_W-1:0]     status,
	output logic [dnt_pkg::SECTOR_IO_W-1:0]  sector_out,
	output logic [dnt_pkg::INDEX_OUT_W-1:0]  index_out,
	output logic                             dir_empty
);

	localparam int IdxW   = $clog2(ENTRIES);
	localparam int NameW  = 8 * NAME_BYTES;
	localparam int WordW  = NameW + 1 + SECTOR_BITS;
	localparam logic [IdxW-1:0]  LastIdx   = IdxW'(ENTRIES - 1);
	localparam logic [NameW-1:0] DotKey    = NameW'(dnt_pkg::KEY_DOT);
	localparam logic [NameW-1:0] DotDotKey =
		(NAME_BYTES >= 2) ? NameW'(dnt_pkg::KEY_DOTDOT) : NameW'(dnt_pkg::KEY_DOT);

	dnt_pkg::dnt_state_t state_q, state_d;

	logic                      req_fire;
	logic                      rsp_fire;
	logic                      fin_fire;
	logic [IdxW-1:0]           cnt_q;
	logic                      ram_re;
	logic [WordW-1:0]          ram_rdata;
	logic                      ram_we;
	logic [IdxW-1:0]           ram_waddr;
	logic [WordW-1:0]          ram_wdata;

	logic [ENTRIES-1:0]        slot_valid_q;
	logic                      cmp_vld_s1;
	logic [IdxW-1:0]           cmp_idx_s1;

	logic [dnt_pkg::REQ_W-1:0] req_q;
	logic [NameW-1:0]          key_q;
	logic                      kind_q;
	logic [SECTOR_BITS-1:0]    sec_q;

	logic                      hit_q;
	logic [IdxW-1:0]           hit_idx_q;
	logic [SECTOR_BITS-1:0]    hit_sec_q;
	logic                      free_q;
	logic [IdxW-1:0]           free_idx_q;
	logic                      busy_q;

	logic                      rsp_valid_q;

	logic [dnt_pkg::NAME_IN_W-1:0]    key_full;
	logic [NameW-1:0]                 key_norm;
	logic [dnt_pkg::SECTOR_MAX_W-1:0] sec_in_ext;
	logic [SECTOR_BITS-1:0]           sec_norm;

	logic [NameW-1:0]          rd_name;
	logic                      rd_kind;
	logic [SECTOR_BITS-1:0]    rd_sector;
	logic                      rd_valid;
	logic                      hit_now;

	logic [dnt_pkg::STATUS_W-1:0]    res_status;
	logic [IdxW-1:0]                 res_idx;
	logic [SECTOR_BITS-1:0]          res_sector;
	logic                            res_empty;
	logic                            res_clr;
	logic [dnt_pkg::INDEX_MAX_W-1:0]  res_idx_ext;
	logic [dnt_pkg::SECTOR_MAX_W-1:0] res_sec_ext;

	// name key: low NAME_BYTES bytes, zero after the first zero byte
	always_comb begin
		logic stop;
		key_full = '0;
		stop = 1'b0;
		for (int b = 0; b < 8; b++) begin
			if (b >= NAME_BYTES || entry_name[8*b +: 8] == 8'd0) begin
				stop = 1'b1;
			end
			if (!stop) begin
				key_full[8*b +: 8] = entry_name[8*b +: 8];
			end
		end
	end
	assign key_norm = key_full[NameW-1:0];

	// sector kept in SECTOR_BITS bits
	assign sec_in_ext = dnt_pkg::SECTOR_MAX_W'(sector_in);
	assign sec_norm   = sec_in_ext[SECTOR_BITS-1:0];

	// handshakes
	assign req_fire  = req_valid && !req_stall;
	assign rsp_fire  = rsp_valid_q && !rsp_stall;
	assign rsp_valid = rsp_valid_q;

	// next state and control
	always_comb begin
		state_d   = state_q;
		req_stall = 1'b1;
		ram_re    = 1'b0;
		fin_fire  = 1'b0;
		unique case (state_q)
			dnt_pkg::ST_IDLE: begin
				req_stall = 1'b0;
				if (req_valid) begin
					state_d = dnt_pkg::ST_SCAN;
				end
			end
			dnt_pkg::ST_SCAN: begin
				ram_re = 1'b1;
				if (cnt_q == LastIdx) begin
					state_d = dnt_pkg::ST_DRAIN;
				end
			end
			dnt_pkg::ST_DRAIN: begin
				state_d = dnt_pkg::ST_FINISH;
			end
			dnt_pkg::ST_FINISH: begin
				if (!rsp_valid_q || !rsp_stall) begin
					fin_fire = 1'b1;
					state_d  = dnt_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = dnt_pkg::ST_IDLE;
			end
		endcase
	end

	// slot memory holds name, kind and sector
	dnt_ram #(
		.DEPTH(ENTRIES),
		.WIDTH(WordW)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (cnt_q),
		.rdata (ram_rdata)
	);

	// compare stage on the slot read last cycle
	assign rd_name   = ram_rdata[WordW-1 -: NameW];
	assign rd_kind   = ram_rdata[SECTOR_BITS];
	assign rd_sector = ram_rdata[SECTOR_BITS-1:0];
	assign rd_valid  = slot_valid_q[cmp_idx_s1];
	assign hit_now   = rd_valid && (rd_name == key_q) && (rd_kind == kind_q);

	// result and write-back of the finish step
	always_comb begin
		res_status = dnt_pkg::STS_OK;
		res_idx    = '0;
		res_sector = '0;
		res_empty  = 1'b0;
		res_clr    = 1'b0;
		ram_we     = 1'b0;
		ram_waddr  = hit_idx_q;
		ram_wdata  = {key_q, kind_q, sec_q};
		unique case (req_q)
			dnt_pkg::REQ_LOOKUP: begin
				if (hit_q) begin
					res_idx    = hit_idx_q;
					res_sector = hit_sec_q;
				end else begin
					res_status = dnt_pkg::STS_NOT_FOUND;
				end
			end
			dnt_pkg::REQ_ADD: begin
				if (hit_q) begin
					res_status = dnt_pkg::STS_DUPLICATE;
					res_idx    = hit_idx_q;
				end else if (free_q) begin
					res_idx   = free_idx_q;
					ram_we    = fin_fire;
					ram_waddr = free_idx_q;
				end else begin
					res_status = dnt_pkg::STS_FULL;
				end
			end
			dnt_pkg::REQ_REMOVE: begin
				if (hit_q) begin
					res_idx = hit_idx_q;
					res_clr = 1'b1;
				end else begin
					res_status = dnt_pkg::STS_NOT_FOUND;
				end
			end
			dnt_pkg::REQ_SET_SECTOR: begin
				if (hit_q) begin
					res_idx = hit_idx_q;
					ram_we  = fin_fire;
				end else begin
					res_status = dnt_pkg::STS_NOT_FOUND;
				end
			end
			dnt_pkg::REQ_EMPTY: begin
				res_empty = !busy_q;
			end
			default: begin
			end
		endcase
	end

	assign res_idx_ext = dnt_pkg::INDEX_MAX_W'(res_idx);
	assign res_sec_ext = dnt_pkg::SECTOR_MAX_W'(res_sector);

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= dnt_pkg::ST_IDLE;
			cnt_q        <= '0;
			cmp_vld_s1   <= 1'b0;
			slot_valid_q <= '0;
			hit_q        <= 1'b0;
			free_q       <= 1'b0;
			busy_q       <= 1'b0;
			rsp_valid_q  <= 1'b0;
		end else begin
			state_q    <= state_d;
			cmp_vld_s1 <= ram_re;
			// slot counter
			if (req_fire) begin
				cnt_q <= '0;
			end else if (ram_re && cnt_q != LastIdx) begin
				cnt_q <= cnt_q + 1'b1;
			end
			// scan flags
			if (req_fire) begin
				hit_q  <= 1'b0;
				free_q <= 1'b0;
				busy_q <= 1'b0;
			end else if (cmp_vld_s1) begin
				if (hit_now) begin
					hit_q <= 1'b1;
				end
				if (!rd_valid) begin
					free_q <= 1'b1;
				end
				if (rd_valid && rd_name != DotKey && rd_name != DotDotKey) begin
					busy_q <= 1'b1;
				end
			end
			// valid bits
			if (fin_fire && ram_we && req_q == dnt_pkg::REQ_ADD) begin
				slot_valid_q[free_idx_q] <= 1'b1;
			end
			if (fin_fire && res_clr) begin
				slot_valid_q[hit_idx_q] <= 1'b0;
			end
			// response valid
			if (fin_fire) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_fire) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		cmp_idx_s1 <= cnt_q;
		if (req_fire) begin
			req_q  <= req_type;
			key_q  <= key_norm;
			kind_q <= is_file;
			sec_q  <= sec_norm;
		end
		if (cmp_vld_s1 && !hit_q && hit_now) begin
			hit_idx_q <= cmp_idx_s1;
			hit_sec_q <= rd_sector;
		end
		if (cmp_vld_s1 && !free_q && !rd_valid) begin
			free_idx_q <= cmp_idx_s1;
		end
		if (fin_fire) begin
			status     <= res_status;
			sector_out <= res_sec_ext[dnt_pkg::SECTOR_IO_W-1:0];
			index_out  <= res_idx_ext[dnt_pkg::INDEX_OUT_W-1:0];
			dir_empty  <= res_empty;
		end
	end

	// an accepted item always starts a scan
	a_accept_scan: assert property (@(posedge clk) disable iff (!arst_n)
		req_fire |=> state_q == dnt_pkg::ST_SCAN)
		else $error("accepted item did not start a scan");

	// a new response only comes out of the finish step
	a_rsp_from_finish: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid_q) |-> $past(state_q) == dnt_pkg::ST_FINISH)
		else $error("response raised outside the finish step");

	// a recorded hit always points at a valid slot while the item is in work
	a_hit_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != dnt_pkg::ST_IDLE && hit_q) |-> slot_valid_q[hit_idx_q])
		else $error("hit recorded on an invalid slot");

	// a successful add leaves its slot valid
	a_add_sets_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(fin_fire && req_q == dnt_pkg::REQ_ADD && !hit_q && free_q)
			|=> slot_valid_q[$past(free_idx_q)])
		else $error("added slot not marked valid");

	// memory writes happen only in the finish step
	a_write_finish: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> state_q == dnt_pkg::ST_FINISH)
		else $error("slot memory written outside the finish step");

endmodule

### test/dnt_table_checker.sv
// request/response checker for the directory name table: predicts and compares every item
`timescale 1ns / 1ps

module dnt_table_checker (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                req_valid,
	input  logic                                req_stall,
	input  logic [dnt_pkg::REQ_W-1:0]           req_type,
	input  logic [dnt_pkg::NAME_IN_W-1:0]       entry_name,
	input  logic                                is_file,
	input  logic [dnt_pkg::SECTOR_IO_W-1:0]     sector_in,
	input  logic                                rsp_valid,
	input  logic                                rsp_stall,
	input  logic [dnt_pkg::STATUS_W-1:0]        status,
	input  logic [dnt_pkg::SECTOR_IO_W-1:0]     sector_out,
	input  logic [dnt_pkg::INDEX_OUT_W-1:0]     index_out,
	input  logic                                dir_empty,
	output int                                  errors,
	output int                                  pending
);

	localparam int ENTRIES = dnt_pkg::ENTRIES_DEF;
	localparam int NO_SLOT = -1;

	typedef struct {
		dnt_pkg::dnt_status_t                st;
		logic [dnt_pkg::SECTOR_IO_W-1:0]     sec;
		logic [dnt_pkg::INDEX_OUT_W-1:0]     idx;
		logic                                empty;
	} answer_t;

	// shadow copy of the slot table
	logic [ENTRIES-1:0]                  slot_valid;
	logic [dnt_pkg::NAME_IN_W-1:0]       slot_name   [ENTRIES];
	logic                                slot_kind   [ENTRIES];
	logic [dnt_pkg::SECTOR_IO_W-1:0]     slot_sector [ENTRIES];

	answer_t owed_answers[$];

	// bytes after the first nul byte do not belong to the key
	function automatic logic [dnt_pkg::NAME_IN_W-1:0] canon_key(
			logic [dnt_pkg::NAME_IN_W-1:0] raw);
		logic [dnt_pkg::NAME_IN_W-1:0] k;
		logic live;
		k = '0;
		live = 1'b1;
		for (int b = 0; b < dnt_pkg::NAME_BYTES_DEF; b++) begin
			if (raw[8*b +: 8] == 8'h00)
				live = 1'b0;
			if (live)
				k[8*b +: 8] = raw[8*b +: 8];
		end
		return k;
	endfunction

	// lowest valid slot with this key and kind
	function automatic int match_slot(logic [dnt_pkg::NAME_IN_W-1:0] key, logic kind);
		for (int i = 0; i < ENTRIES; i++)
			if (slot_valid[i] && slot_name[i] == key && slot_kind[i] == kind)
				return i;
		return NO_SLOT;
	endfunction

	// apply one request to the shadow table and return the answer it owes
	function automatic answer_t table_outcome(logic [dnt_pkg::REQ_W-1:0] op,
			logic [dnt_pkg::NAME_IN_W-1:0] raw, logic kind,
			logic [dnt_pkg::SECTOR_IO_W-1:0] sec);
		answer_t a;
		logic [dnt_pkg::NAME_IN_W-1:0] key;
		int hit;
		key = canon_key(raw);
		hit = match_slot(key, kind);
		a.st = dnt_pkg::STS_OK;
		a.sec = '0;
		a.idx = '0;
		a.empty = 1'b0;
		case (op)
		dnt_pkg::REQ_LOOKUP: begin
			if (hit == NO_SLOT) begin
				a.st = dnt_pkg::STS_NOT_FOUND;
			end else begin
				a.sec = slot_sector[hit];
				a.idx = dnt_pkg::INDEX_OUT_W'(hit);
			end
		end
		dnt_pkg::REQ_ADD: begin
			if (hit != NO_SLOT) begin
				a.st = dnt_pkg::STS_DUPLICATE;
				a.idx = dnt_pkg::INDEX_OUT_W'(hit);
			end else begin
				a.st = dnt_pkg::STS_FULL;
				for (int i = 0; i < ENTRIES; i++) begin
					if (a.st == dnt_pkg::STS_FULL && !slot_valid[i]) begin
						slot_valid[i] = 1'b1;
						slot_name[i] = key;
						slot_kind[i] = kind;
						slot_sector[i] = sec;
						a.st = dnt_pkg::STS_OK;
						a.idx = dnt_pkg::INDEX_OUT_W'(i);
					end
				end
			end
		end
		dnt_pkg::REQ_REMOVE: begin
			if (hit == NO_SLOT) begin
				a.st = dnt_pkg::STS_NOT_FOUND;
			end else begin
				slot_valid[hit] = 1'b0;
				a.idx = dnt_pkg::INDEX_OUT_W'(hit);
			end
		end
		dnt_pkg::REQ_SET_SECTOR: begin
			if (hit == NO_SLOT) begin
				a.st = dnt_pkg::STS_NOT_FOUND;
			end else begin
				slot_sector[hit] = sec;
				a.idx = dnt_pkg::INDEX_OUT_W'(hit);
			end
		end
		dnt_pkg::REQ_EMPTY: begin
			// dot and dot-dot never count, whatever their kind
			a.empty = 1'b1;
			for (int i = 0; i < ENTRIES; i++)
				if (slot_valid[i] && slot_name[i] != dnt_pkg::KEY_DOT
						&& slot_name[i] != dnt_pkg::KEY_DOTDOT)
					a.empty = 1'b0;
		end
		default: begin
		end
		endcase
		return a;
	endfunction

	// compare responses, then queue the answer of a newly taken request
	always @(posedge clk or negedge arst_n) begin
		answer_t want;
		int miss;
		if (!arst_n) begin
			slot_valid = '0;
			owed_answers.delete();
			errors <= 0;
			pending <= 0;
		end else begin
			miss = 0;
			if (rsp_valid && !rsp_stall) begin
				if (owed_answers.size() == 0) begin
					$error("response item with no request outstanding: status %0d index %0d",
						status, index_out);
					miss++;
				end else begin
					want = owed_answers.pop_front();
					if (status !== want.st) begin
						$error("status: expected %0d, got %0d", want.st, status);
						miss++;
					end
					if (sector_out !== want.sec) begin
						$error("sector_out: expected %0d, got %0d", want.sec, sector_out);
						miss++;
					end
					if (index_out !== want.idx) begin
						$error("index_out: expected %0d, got %0d", want.idx, index_out);
						miss++;
					end
					if (dir_empty !== want.empty) begin
						$error("dir_empty: expected %0d, got %0d", want.empty, dir_empty);
						miss++;
					end
				end
			end
			if (req_valid && !req_stall)
				owed_answers.push_back(table_outcome(req_type, entry_name, is_file, sector_in));
			errors <= errors + miss;
			pending <= owed_answers.size();
		end
	end

endmodule

### test/tb_directory_name_table.sv
// top-level testbench of the directory name table: clock, reset, stimulus and verdict
`timescale 1ns / 1ps

module tb_directory_name_table;

	localparam int ENTRIES     = dnt_pkg::ENTRIES_DEF;
	localparam int POOL        = 20;
	localparam int PHASE_ITEMS = 400;
	localparam int QUIET_LIMIT = 4000;
	localparam logic [dnt_pkg::NAME_IN_W-1:0] NAME_ONES = '1;

	logic                                clk = 1'b0;
	logic                                arst_n = 1'b0;
	logic                                req_valid = 1'b0;
	logic                                req_stall;
	logic [dnt_pkg::REQ_W-1:0]           req_type = '0;
	logic [dnt_pkg::NAME_IN_W-1:0]       entry_name = '0;
	logic                                is_file = 1'b0;
	logic [dnt_pkg::SECTOR_IO_W-1:0]     sector_in = '0;
	logic                                rsp_valid;
	logic                                rsp_stall = 1'b0;
	logic [dnt_pkg::STATUS_W-1:0]        status;
	logic [dnt_pkg::SECTOR_IO_W-1:0]     sector_out;
	logic [dnt_pkg::INDEX_OUT_W-1:0]     index_out;
	logic                                dir_empty;

	int errors;
	int pending;
	int idle_pct = 0;
	int stall_pct = 0;
	int quiet_cycles = 0;

	logic [dnt_pkg::NAME_IN_W-1:0] name_pool [POOL];
	logic                          kind_pool [POOL];

	directory_name_table u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_valid  (req_valid),
		.req_stall  (req_stall),
		.req_type   (req_type),
		.entry_name (entry_name),
		.is_file    (is_file),
		.sector_in  (sector_in),
		.rsp_valid  (rsp_valid),
		.rsp_stall  (rsp_stall),
		.status     (status),
		.sector_out (sector_out),
		.index_out  (index_out),
		.dir_empty  (dir_empty)
	);

	dnt_table_checker u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_valid  (req_valid),
		.req_stall  (req_stall),
		.req_type   (req_type),
		.entry_name (entry_name),
		.is_file    (is_file),
		.sector_in  (sector_in),
		.rsp_valid  (rsp_valid),
		.rsp_stall  (rsp_stall),
		.status     (status),
		.sector_out (sector_out),
		.index_out  (index_out),
		.dir_empty  (dir_empty),
		.errors     (errors),
		.pending    (pending)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	// random backpressure on the response side
	always @(negedge clk) begin
		rsp_stall <= ($urandom_range(99) < stall_pct);
	end

	// watchdog: too long without any item moving on either channel
	always @(posedge clk) begin
		if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("tb_directory_name_table failed");
			$finish;
		end
	end

	// one request item, with random idle cycles ahead of it
	task automatic issue_request(logic [dnt_pkg::REQ_W-1:0] op,
			logic [dnt_pkg::NAME_IN_W-1:0] name, logic kind,
			logic [dnt_pkg::SECTOR_IO_W-1:0] sec);
		@(negedge clk);
		while ($urandom_range(99) < idle_pct) begin
			req_valid <= 1'b0;
			@(negedge clk);
		end
		req_valid <= 1'b1;
		req_type <= op;
		entry_name <= name;
		is_file <= kind;
		sector_in <= sec;
		do @(posedge clk); while (req_stall);
	endtask

	// hold the request side off until every response is back
	task automatic drain_responses();
		@(negedge clk);
		req_valid <= 1'b0;
		wait (pending == 0);
	endtask

	// random garbage in the bytes past the first nul, which the key ignores
	function automatic logic [dnt_pkg::NAME_IN_W-1:0] dress_name(
			logic [dnt_pkg::NAME_IN_W-1:0] key);
		logic [dnt_pkg::NAME_IN_W-1:0] raw;
		logic seen_nul;
		raw = key;
		seen_nul = 1'b0;
		for (int b = 0; b < dnt_pkg::NAME_BYTES_DEF; b++) begin
			if (seen_nul && $urandom_range(1))
				raw[8*b +: 8] = 8'($urandom);
			if (key[8*b +: 8] == 8'h00)
				seen_nul = 1'b1;
		end
		return raw;
	endfunction

	// mostly pool names so entries get hit; bias swings between filling and emptying
	task automatic random_phase(int n_items);
		logic [dnt_pkg::REQ_W-1:0] op;
		logic [dnt_pkg::NAME_IN_W-1:0] name;
		logic kind;
		logic fill_bias;
		int pick;
		int r;
		fill_bias = 1'b0;
		for (int i = 0; i < n_items; i++) begin
			if (i % 50 == 0)
				fill_bias = !fill_bias;
			if ($urandom_range(99) < 8) begin
				issue_request(dnt_pkg::REQ_W'($urandom), {$urandom, $urandom}, 1'($urandom),
					dnt_pkg::SECTOR_IO_W'($urandom));
			end else begin
				pick = $urandom_range(POOL - 1);
				name = $urandom_range(1) ? dress_name(name_pool[pick]) : name_pool[pick];
				kind = ($urandom_range(3) == 0) ? !kind_pool[pick] : kind_pool[pick];
				r = $urandom_range(99);
				if (r < (fill_bias ? 45 : 15))
					op = dnt_pkg::REQ_ADD;
				else if (r < 55)
					op = dnt_pkg::REQ_REMOVE;
				else if (r < 78)
					op = dnt_pkg::REQ_LOOKUP;
				else if (r < 90)
					op = dnt_pkg::REQ_SET_SECTOR;
				else
					op = dnt_pkg::REQ_EMPTY;
				issue_request(op, name, kind, dnt_pkg::SECTOR_IO_W'($urandom));
			end
		end
	endtask

	initial begin
		// name pool: dot entries, extreme keys, then random names of every length
		name_pool[0] = dnt_pkg::KEY_DOT;
		name_pool[1] = dnt_pkg::KEY_DOTDOT;
		name_pool[2] = NAME_ONES;
		name_pool[3] = '0;
		for (int p = 4; p < POOL; p++) begin
			name_pool[p] = '0;
			for (int b = 0; b < $urandom_range(1, dnt_pkg::NAME_BYTES_DEF); b++)
				name_pool[p][8*b +: 8] = 8'($urandom_range(1, 255));
		end
		for (int p = 0; p < POOL; p++)
			kind_pool[p] = 1'($urandom);

		repeat (6) @(negedge clk);
		arst_n <= 1'b1;

		// directed: empty table, dot entries, kinds, duplicates, key padding, bad codes
		issue_request(dnt_pkg::REQ_EMPTY, '0, 1'b0, '0);
		issue_request(dnt_pkg::REQ_LOOKUP, 64'h6261, 1'b1, '0);
		issue_request(dnt_pkg::REQ_ADD, dnt_pkg::KEY_DOT, 1'b0, '0);
		issue_request(dnt_pkg::REQ_ADD, dnt_pkg::KEY_DOTDOT, 1'b0, '1);
		issue_request(dnt_pkg::REQ_ADD, dnt_pkg::KEY_DOT, 1'b1, 10'd7);
		issue_request(dnt_pkg::REQ_EMPTY, NAME_ONES, 1'b1, '1);
		issue_request(dnt_pkg::REQ_SET_SECTOR, dnt_pkg::KEY_DOTDOT, 1'b0, 10'd512);
		issue_request(dnt_pkg::REQ_LOOKUP, dnt_pkg::KEY_DOTDOT, 1'b0, '0);
		issue_request(dnt_pkg::REQ_ADD, NAME_ONES, 1'b1, '1);
		issue_request(dnt_pkg::REQ_ADD, NAME_ONES, 1'b1, '0);
		issue_request(dnt_pkg::REQ_LOOKUP, NAME_ONES, 1'b0, '0);
		issue_request(dnt_pkg::REQ_ADD, '0, 1'b0, '0);
		issue_request(dnt_pkg::REQ_EMPTY, '0, 1'b0, '0);
		issue_request(dnt_pkg::REQ_ADD, 64'h41, 1'b1, 10'd3);
		issue_request(dnt_pkg::REQ_LOOKUP, 64'hA5C3_0000_5A00_0041, 1'b1, '0);
		issue_request(dnt_pkg::REQ_REMOVE, 64'hFF00_0000_0000_0041, 1'b1, '0);
		issue_request(dnt_pkg::REQ_REMOVE, 64'h41, 1'b1, '0);
		issue_request(dnt_pkg::REQ_SET_SECTOR, 64'h7A7A, 1'b0, 10'd1);
		for (int t = dnt_pkg::REQ_EMPTY + 1; t < 2 ** dnt_pkg::REQ_W; t++)
			issue_request(dnt_pkg::REQ_W'(t), NAME_ONES, 1'b1, '1);
		// fill the table up to a refused add
		for (int n = 0; n < ENTRIES - 4; n++)
			issue_request(dnt_pkg::REQ_ADD, {48'h0, 8'(8'h61 + n), 8'h66}, 1'b0,
				dnt_pkg::SECTOR_IO_W'(n));
		issue_request(dnt_pkg::REQ_EMPTY, '0, 1'b0, '0);
		drain_responses();

		// random part under three idling patterns
		idle_pct = 35;
		stall_pct = 51;
		random_phase(PHASE_ITEMS);
		drain_responses();
		idle_pct = 51;
		stall_pct = 35;
		random_phase(PHASE_ITEMS);
		drain_responses();
		idle_pct = 0;
		stall_pct = 0;
		random_phase(PHASE_ITEMS);

		drain_responses();
		repeat (2 * ENTRIES + 8) @(posedge clk);
		if (errors == 0)
			$display("tb_directory_name_table passed");
		else
			$display("tb_directory_name_table failed");
		$finish;
	end

endmodule
